// ----- rtl/mdp_pkg.sv -----
package mdp_pkg;

    localparam int CHAR_W    = 8;
    localparam int MIN_LEN_W = 11;
    localparam int COUNT_W   = 11;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Broadcast strobes from the controller to every cell
    typedef struct packed {
        logic upd;    // a new byte is being taken at pos
        logic start;  // launch the scan token at cell pos
        logic clr;    // end of string: drop all palindrome bits
        logic wr;     // scan done: store prefix count in cell pos+1
    } ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } state_t;

endpackage

// ----- rtl/max_disjoint_palindromes.sv -----
// A byte at position p is scanned by a token walking the cell chain one cell
// per cycle, from cell p down to cell 0; no new byte is taken until the scan
// is done. The result is presented on the item marked last.
// A byte beyond MAX_LEN is dropped (if it is marked last, the result is presented).
// Reset (aresetn low, synchronous) empties the string and sets min_len to 1.
module max_disjoint_palindromes #(
    parameter int MAX_LEN = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mdp_pkg::MIN_LEN_W-1:0]     cfg_min_len,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [mdp_pkg::CHAR_W-1:0]       s_char_in,
    input  logic                              s_is_last,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [mdp_pkg::COUNT_W-1:0]       m_best_count,
    output logic                              m_overflow
);
    import mdp_pkg::*;

    localparam int PW = $clog2(MAX_LEN + 1);
    localparam int CW = (PW > MIN_LEN_W) ? PW : MIN_LEN_W;
    localparam int SW = (PW > COUNT_W) ? PW : COUNT_W;

    state_t            state_reg, state_next;
    logic [PW-1:0]     pos_reg;
    logic              ovf_reg, last_reg, start_reg;
    logic [PW-1:0]     res_reg;
    logic [MIN_LEN_W-1:0] min_len_reg;
    logic              m_valid_reg;
    logic [COUNT_W-1:0] m_best_reg;
    logic              m_ovf_reg;

    logic s_fire, room, scan_done, out_free, fin_go;
    ctl_t ctl;

    logic          pal_w [0:MAX_LEN+1];
    logic          tok_w [0:MAX_LEN+1];
    logic [PW-1:0] max_w [0:MAX_LEN+1];
    logic [PW-1:0] len_w [0:MAX_LEN+1];

    assign cfg_ready = 1'b1;
    assign s_fire    = s_valid && s_ready;
    assign room      = (pos_reg < PW'(MAX_LEN));
    assign scan_done = tok_w[0];
    assign out_free  = !m_valid_reg || m_ready;
    assign fin_go    = (state_reg == ST_FIN) && out_free;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (room) state_next = ST_SCAN;
                    else if (s_is_last) state_next = ST_FIN;
                end
            end
            ST_SCAN: begin
                if (scan_done) state_next = last_reg ? ST_FIN : ST_IDLE;
            end
            ST_FIN: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and cell strobes
    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        ctl.upd   = s_fire && room;
        ctl.start = start_reg;
        ctl.clr   = fin_go;
        ctl.wr    = (state_reg == ST_SCAN) && scan_done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pos_reg     <= '0;
            ovf_reg     <= 1'b0;
            last_reg    <= 1'b0;
            start_reg   <= 1'b0;
            min_len_reg <= MIN_LEN_W'(1);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            start_reg <= ctl.upd;
            if (cfg_valid) min_len_reg <= cfg_min_len;
            if (s_fire) begin
                last_reg <= s_is_last;
                if (!room) ovf_reg <= 1'b1;
            end
            if (ctl.wr) pos_reg <= pos_reg + PW'(1);
            if (fin_go) begin
                pos_reg <= '0;
                ovf_reg <= 1'b0;
            end
            if (fin_go) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    // result payload, saturated to the field, zero on overflow
    always_ff @(posedge aclk) begin
        if (ctl.wr) res_reg <= max_w[0];
        if (fin_go) begin
            m_ovf_reg <= ovf_reg;
            if (ovf_reg) m_best_reg <= '0;
            else if (SW'(res_reg) > SW'(COUNT_MAX)) m_best_reg <= COUNT_MAX;
            else m_best_reg <= COUNT_W'(res_reg);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_best_count = m_best_reg;
    assign m_overflow   = m_ovf_reg;

    // chain end
    assign pal_w[MAX_LEN+1] = 1'b0;
    assign tok_w[MAX_LEN+1] = 1'b0;
    assign max_w[MAX_LEN+1] = '0;
    assign len_w[MAX_LEN+1] = '0;

    for (genvar gi = 0; gi <= MAX_LEN; gi++) begin : g_cell
        mdp_cell #(
            .IDX (gi),
            .PW  (PW),
            .CW  (CW)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl),
            .pos     (pos_reg),
            .min_len (min_len_reg),
            .ch      (s_char_in),
            .wdata   (max_w[0]),
            .nb_pal  (pal_w[gi+1]),
            .nb_tok  (tok_w[gi+1]),
            .nb_max  (max_w[gi+1]),
            .nb_len  (len_w[gi+1]),
            .pal     (pal_w[gi]),
            .tok     (tok_w[gi]),
            .best    (max_w[gi]),
            .len     (len_w[gi])
        );
    end

endmodule

// ----- rtl/mdp_cell.sv -----
module mdp_cell #(
    parameter int IDX = 0,
    parameter int PW  = 11,
    parameter int CW  = 11
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  mdp_pkg::ctl_t                         ctl,
    input  logic [PW-1:0]                         pos,
    input  logic [mdp_pkg::MIN_LEN_W-1:0]         min_len,
    input  logic [mdp_pkg::CHAR_W-1:0]           ch,
    input  logic [PW-1:0]                         wdata,
    // neighbor at the next higher index
    input  logic                                  nb_pal,
    input  logic                                  nb_tok,
    input  logic [PW-1:0]                         nb_max,
    input  logic [PW-1:0]                         nb_len,
    output logic                                  pal,
    output logic                                  tok,
    output logic [PW-1:0]                         best,
    output logic [PW-1:0]                         len
);
    import mdp_pkg::*;

    logic [CHAR_W-1:0] char_reg;
    logic              pal_reg,  pal_next;
    logic [PW-1:0]     pfx_reg;
    logic              tok_reg,  tok_next;
    logic [PW-1:0]     max_reg,  max_next;
    logic [PW-1:0]     len_reg,  len_next;

    logic          at_pos, below_pos, next_is_pos, wr_here, start_here;
    logic [PW-1:0] in_max, in_len, cand;
    logic          qual;

    assign at_pos      = (pos == PW'(IDX));
    assign below_pos   = (PW'(IDX) < pos) && (IDX < (1 << PW));
    assign next_is_pos = (pos == PW'(IDX + 1));
    assign wr_here     = ctl.wr && (IDX != 0) && (pos == PW'(IDX - 1));
    assign start_here  = ctl.start && at_pos;

    // palindrome bit: extend j+1..p-1 by one matching pair
    always_comb begin
        pal_next = pal_reg;
        if (ctl.clr) begin
            pal_next = 1'b0;
        end else if (ctl.upd && below_pos) begin
            pal_next = (char_reg == ch) && (next_is_pos || nb_pal);
        end else if (ctl.upd && at_pos) begin
            pal_next = 1'b1;
        end
    end

    // scan token: running max walks from cell p down to cell 0
    always_comb begin
        if (start_here) begin
            in_max = pfx_reg;
            in_len = PW'(1);
        end else begin
            in_max = nb_max;
            in_len = nb_len + PW'(1);
        end
        cand     = pfx_reg + PW'(1);
        qual     = pal_reg && (CW'(in_len) >= CW'(min_len));
        tok_next = start_here || nb_tok;
        max_next = (qual && (cand > in_max)) ? cand : in_max;
        len_next = in_len;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pal_reg <= 1'b0;
            tok_reg <= 1'b0;
            pfx_reg <= '0;
        end else begin
            pal_reg <= pal_next;
            tok_reg <= tok_next;
            if (wr_here) begin
                pfx_reg <= wdata;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (ctl.upd && at_pos) begin
            char_reg <= ch;
        end
        max_reg <= max_next;
        len_reg <= len_next;
    end

    assign pal  = pal_reg;
    assign tok  = tok_reg;
    assign best = max_reg;
    assign len  = len_reg;

endmodule
